>>> rtl/sec_pkg.sv
package sec_pkg;

    localparam logic [7:0] ESC_BYTE = 8'hD8;
    localparam logic [7:0] RSV_BYTE = 8'hD9;
    localparam logic [2:0] RUN_MAX  = 3'd5;

    typedef enum logic [2:0] {
        KIND_LIT,
        KIND_PAIR,
        KIND_PAIR_LIT,
        KIND_EXPAND,
        KIND_MARK
    } t_kind;

    // one classified input item, as handed from the front to the back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic [7:0] lit;
        logic       last;
        logic       err;
    } t_cmd;

endpackage

>>> rtl/sec_if.sv
interface sec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       frame_end;
    logic       escape_error;

    modport source (
        output valid, output out_byte, output byte_valid, output run_last,
        output frame_end, output escape_error, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input run_last,
        input frame_end, input escape_error, output ready
    );
endinterface

>>> rtl/sec_front.sv
module sec_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    sec_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output sec_pkg::t_cmd o_cmd
);

    logic       r_decode_mode;
    logic [2:0] r_run_count;
    logic [4:0] r_run_flags;
    logic       r_await;
    logic [2:0] n_run_count;
    logic [4:0] n_run_flags;
    logic       n_await;

    logic       accept;
    logic       is_esc;
    logic       is_rsv;
    logic [2:0] cnt_add;
    logic [4:0] flags_add;
    logic       want_push;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign is_esc     = (i_in.in_byte == sec_pkg::ESC_BYTE);
    assign is_rsv     = (i_in.in_byte == sec_pkg::RSV_BYTE);
    assign cnt_add    = r_run_count + 3'd1;
    assign flags_add  = r_run_flags | (is_rsv ? (5'd1 << r_run_count) : 5'd0);
    assign o_push     = accept && want_push;

    always_comb begin
        want_push   = 1'b0;
        o_cmd.kind  = sec_pkg::KIND_LIT;
        o_cmd.code  = 8'd0;
        o_cmd.lit   = i_in.in_byte;
        o_cmd.last  = i_in.in_last;
        o_cmd.err   = 1'b0;
        n_run_count = r_run_count;
        n_run_flags = r_run_flags;
        n_await     = r_await;
        if (!r_decode_mode) begin
            if (is_esc || is_rsv) begin
                if (cnt_add == sec_pkg::RUN_MAX || i_in.in_last) begin
                    want_push   = 1'b1;
                    o_cmd.kind  = sec_pkg::KIND_PAIR;
                    o_cmd.code  = {cnt_add, flags_add};
                    n_run_count = 3'd0;
                    n_run_flags = 5'd0;
                end else begin
                    n_run_count = cnt_add;
                    n_run_flags = flags_add;
                end
            end else begin
                want_push   = 1'b1;
                o_cmd.kind  = (r_run_count != 3'd0) ? sec_pkg::KIND_PAIR_LIT
                                                    : sec_pkg::KIND_LIT;
                o_cmd.code  = {r_run_count, r_run_flags};
                n_run_count = 3'd0;
                n_run_flags = 5'd0;
            end
        end else begin
            if (r_await) begin
                n_await    = 1'b0;
                o_cmd.code = i_in.in_byte;
                if (i_in.in_byte[7:5] != 3'd0) begin
                    want_push  = 1'b1;
                    o_cmd.kind = sec_pkg::KIND_EXPAND;
                end else if (i_in.in_last) begin
                    want_push  = 1'b1;
                    o_cmd.kind = sec_pkg::KIND_MARK;
                end
            end else if (is_esc) begin
                n_await = 1'b1;
                if (i_in.in_last) begin
                    // dangling escape at frame end
                    want_push  = 1'b1;
                    o_cmd.kind = sec_pkg::KIND_MARK;
                    o_cmd.err  = 1'b1;
                end
            end else begin
                want_push = 1'b1;
            end
        end
        if (i_in.in_last) begin
            n_run_count = 3'd0;
            n_run_flags = 5'd0;
            n_await     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_run_count   <= 3'd0;
            r_run_flags   <= 5'd0;
            r_await       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_decode_mode <= i_cfg_wr_data;
            r_run_count   <= 3'd0;
            r_run_flags   <= 5'd0;
            r_await       <= 1'b0;
        end else if (accept) begin
            r_run_count <= n_run_count;
            r_run_flags <= n_run_flags;
            r_await     <= n_await;
        end
    end

endmodule

>>> rtl/sec_queue.sv
module sec_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sec_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sec_pkg::t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sec_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == CW'(0));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/sec_back.sv
module sec_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sec_pkg::t_cmd i_head,
    output logic          o_pop,
    sec_out_if.source     o_out
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_byte_valid;
    logic       r_run_last;
    logic       r_frame_end;
    logic       r_escape_error;

    logic [7:0] item_byte;
    logic       item_valid;
    logic       item_fin;
    logic       load;

    // result at position r_idx of the head command
    always_comb begin
        item_byte  = i_head.lit;
        item_valid = 1'b1;
        item_fin   = 1'b1;
        unique case (i_head.kind)
            sec_pkg::KIND_LIT: begin
                item_byte = i_head.lit;
            end
            sec_pkg::KIND_PAIR: begin
                item_byte = (r_idx == 3'd0) ? sec_pkg::ESC_BYTE : i_head.code;
                item_fin  = (r_idx == 3'd1);
            end
            sec_pkg::KIND_PAIR_LIT: begin
                case (r_idx)
                    3'd0:    item_byte = sec_pkg::ESC_BYTE;
                    3'd1:    item_byte = i_head.code;
                    default: item_byte = i_head.lit;
                endcase
                item_fin = (r_idx == 3'd2);
            end
            sec_pkg::KIND_EXPAND: begin
                item_byte = i_head.code[r_idx] ? sec_pkg::RSV_BYTE : sec_pkg::ESC_BYTE;
                item_fin  = (r_idx == i_head.code[7:5] - 3'd1);
            end
            sec_pkg::KIND_MARK: begin
                item_byte  = 8'd0;
                item_valid = 1'b0;
            end
            default: begin
                item_byte  = 8'd0;
                item_valid = 1'b0;
            end
        endcase
    end

    assign load  = !i_empty && (!r_valid || o_out.ready);
    assign o_pop = load && item_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= item_fin ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte         <= item_byte;
            r_byte_valid   <= item_valid;
            r_run_last     <= item_fin;
            r_frame_end    <= item_fin && i_head.last;
            r_escape_error <= item_fin && i_head.err;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.byte_valid   = r_byte_valid;
    assign o_out.run_last     = r_run_last;
    assign o_out.frame_end    = r_frame_end;
    assign o_out.escape_error = r_escape_error;

endmodule

>>> rtl/stream_escape_run_codec.sv
// queue: up to QUEUE_DEPTH classified items wait between the sides
// throughput: one input item per cycle unless the queue is full, one result per cycle while
//   the output is ready; an item with n results holds the output side until all n are sent
// reset: synchronous, active low; selects encode mode, clears the pending run and escape,
//   empties the queue and the output register
module stream_escape_run_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    sec_in_if.sink    i_in,
    sec_out_if.source o_out
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    sec_pkg::t_cmd cmd;
    sec_pkg::t_cmd head;

    sec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    sec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    sec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
